// ----- rtl/core/shortest_window_sum_at_least_macros.svh -----
// Assertion macros for the shortest-window-sum RTL.
`ifndef SHORTEST_WINDOW_SUM_AT_LEAST_MACROS_SVH
`define SHORTEST_WINDOW_SUM_AT_LEAST_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWSAL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWSAL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/core/swsal_pkg.sv -----
// Package with shared types and constants of the shortest-window-sum block.
`default_nettype none
package swsal_pkg;

   localparam int TARGET_BITS = 26;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SUB
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ring_ctl_type;

endpackage
`default_nettype wire

// ----- rtl/core/swsal_ring.sv -----
// Window ring memory: one write port, one read port with registered data.
`default_nettype none
module swsal_ring #(
   parameter int DEPTH      = 1024,
   parameter int VALUE_BITS = 16,
   parameter int PTR_BITS   = 10
) (
   input  wire logic                      clock,
   input  wire swsal_pkg::ring_ctl_type   ctl,
   input  wire logic [PTR_BITS-1:0]       wr_addr,
   input  wire logic [VALUE_BITS-1:0]     wr_data,
   input  wire logic [PTR_BITS-1:0]       rd_addr,
   output logic      [VALUE_BITS-1:0]     rd_data_ff
);

   logic [VALUE_BITS-1:0] ring_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         ring_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ----- rtl/core/swsal_ctrl.sv -----
// Window sequencer: pointers, running sum, best length and the drop loop.
`default_nettype none
`include "shortest_window_sum_at_least_macros.svh"
module swsal_ctrl #(
   parameter int DEPTH      = 1024,
   parameter int VALUE_BITS = 16,
   parameter int PTR_BITS   = 10,
   parameter int LEN_BITS   = 11
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [swsal_pkg::TARGET_BITS-1:0]   csr_wdata,
   input  wire logic                                in_valid,
   output logic                                     in_ready,
   input  wire logic [VALUE_BITS-1:0]               in_value,
   input  wire logic                                in_last,
   input  wire logic                                out_busy,
   output logic                                     emit,
   output logic      [LEN_BITS-1:0]                 emit_len,
   output logic                                     emit_ovf,
   output swsal_pkg::ring_ctl_type                  ring_ctl,
   output logic      [PTR_BITS-1:0]                 ring_wr_addr,
   output logic      [PTR_BITS-1:0]                 ring_rd_addr,
   input  wire logic [VALUE_BITS-1:0]               ring_rd_data
);

   localparam int WIDE_BITS = (swsal_pkg::TARGET_BITS > VALUE_BITS) ?
                              swsal_pkg::TARGET_BITS : VALUE_BITS;
   localparam int SUM_BITS  = WIDE_BITS + 1;

   swsal_pkg::state_type              state_ff, state_in;
   logic [swsal_pkg::TARGET_BITS-1:0] target_ff;
   logic [SUM_BITS-1:0]               sum_ff, sum_in;
   logic [PTR_BITS-1:0]               front_ff, front_in;
   logic [PTR_BITS-1:0]               back_ff, back_in;
   logic [LEN_BITS-1:0]               count_ff, count_in;
   logic [LEN_BITS-1:0]               best_ff, best_in;
   logic [LEN_BITS-1:0]               seen_ff, seen_in;
   logic                              ovf_ff, ovf_in;
   logic                              last_ff, last_in;
   logic                              drop;
   logic                              full;

   function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
      return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full         = (seen_ff >= LEN_BITS'(DEPTH));
   assign drop         = (count_ff != '0) && (sum_ff >= SUM_BITS'(target_ff));
   assign ring_wr_addr = back_ff;
   assign ring_rd_addr = front_ff;
   assign emit_len     = best_ff;
   assign emit_ovf     = ovf_ff;

   always_comb begin
      state_in       = state_ff;
      sum_in         = sum_ff;
      front_in       = front_ff;
      back_in        = back_ff;
      count_in       = count_ff;
      best_in        = best_ff;
      seen_in        = seen_ff;
      ovf_in         = ovf_ff;
      last_in        = last_ff;
      in_ready       = 1'b0;
      emit           = 1'b0;
      ring_ctl.wr_en = 1'b0;
      ring_ctl.rd_en = 1'b0;
      case (state_ff)
         swsal_pkg::ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               last_in  = in_last;
               state_in = swsal_pkg::ST_CHECK;
               if (full) begin
                  ovf_in = 1'b1;
               end else begin
                  ring_ctl.wr_en = 1'b1;
                  back_in        = ptr_next(back_ff);
                  sum_in         = sum_ff + SUM_BITS'(in_value);
                  count_in       = count_ff + 1'b1;
                  seen_in        = seen_ff + 1'b1;
               end
            end
         end
         swsal_pkg::ST_CHECK: begin
            if (drop) begin
               // record candidate, fetch front value and retire it
               if ((best_ff == '0) || (count_ff < best_ff)) begin
                  best_in = count_ff;
               end
               ring_ctl.rd_en = 1'b1;
               front_in       = ptr_next(front_ff);
               count_in       = count_ff - 1'b1;
               state_in       = swsal_pkg::ST_SUB;
            end else if (last_ff) begin
               // hold until the output register can take the result
               if (!out_busy) begin
                  emit     = 1'b1;
                  sum_in   = '0;
                  front_in = '0;
                  back_in  = '0;
                  count_in = '0;
                  best_in  = '0;
                  seen_in  = '0;
                  ovf_in   = 1'b0;
                  last_in  = 1'b0;
                  state_in = swsal_pkg::ST_IDLE;
               end
            end else begin
               state_in = swsal_pkg::ST_IDLE;
            end
         end
         swsal_pkg::ST_SUB: begin
            sum_in   = sum_ff - SUM_BITS'(ring_rd_data);
            state_in = swsal_pkg::ST_CHECK;
         end
         default: begin
            state_in = swsal_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= swsal_pkg::ST_IDLE;
         target_ff <= swsal_pkg::TARGET_BITS'(1);
         sum_ff    <= '0;
         front_ff  <= '0;
         back_ff   <= '0;
         count_ff  <= '0;
         best_ff   <= '0;
         seen_ff   <= '0;
         ovf_ff    <= 1'b0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         sum_ff    <= sum_in;
         front_ff  <= front_in;
         back_ff   <= back_in;
         count_ff  <= count_in;
         best_ff   <= best_in;
         seen_ff   <= seen_in;
         ovf_ff    <= ovf_in;
         last_ff   <= last_in;
         if (csr_we) begin
            target_ff <= csr_wdata;
         end
      end
   end

   `SWSAL_ASSERT_NOW(a_count_bound, clock, reset, 1'b1,
      (count_ff <= seen_ff) && (seen_ff <= LEN_BITS'(DEPTH)),
      "window count exceeds items seen or depth")
   `SWSAL_ASSERT_NOW(a_empty_ptrs, clock, reset, count_ff == '0,
      front_ff == back_ff, "empty window with unequal pointers")
   `SWSAL_ASSERT_NOW(a_best_bound, clock, reset, best_ff != '0,
      best_ff <= seen_ff, "best length beyond items seen")
   `SWSAL_ASSERT_NEXT(a_sub_after_read, clock, reset, ring_ctl.rd_en,
      state_ff == swsal_pkg::ST_SUB, "ring read not followed by subtract")

endmodule
`default_nettype wire

// ----- rtl/core/shortest_window_sum_at_least.sv -----
// Top level of the shortest-window-sum block: stream ports and result register.
// Accepts non-negative values, one per transfer, with tlast on the final value
// of a sequence, and after that value returns one transfer holding the length
// of the shortest run of consecutive values whose sum reaches the target (0
// when none does) and a flag set when more than DEPTH values arrived and the
// extra ones were ignored. Each value is accepted and then given a window
// check; each value dropped from the window front adds a ring read with
// registered data and then a subtract, after which the window is checked
// again. A value is dropped at most once. A new value is taken only once the
// checks for the last one are done. The target register is written whenever
// csr_we is high and resets to 1; the ring needs no clearing after reset.
`default_nettype none
module shortest_window_sum_at_least #(
   parameter int DEPTH      = 1024,
   parameter int VALUE_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [swsal_pkg::TARGET_BITS-1:0]   csr_wdata,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [VALUE_BITS-1:0] sample_value, rest zero
   input  wire logic [((VALUE_BITS+7)/8)*8-1:0]     req_tdata,
   input  wire logic                                req_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [LEN_BITS-1:0] min_length, [LEN_BITS] overflowed, rest zero
   output logic [(($clog2(DEPTH+1)+8)/8)*8-1:0]     rsp_tdata
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int LEN_BITS = $clog2(DEPTH + 1);
   localparam int RSP_BITS = ((LEN_BITS + 8) / 8) * 8;

   swsal_pkg::ring_ctl_type ring_ctl;
   logic [PTR_BITS-1:0]     ring_wr_addr;
   logic [PTR_BITS-1:0]     ring_rd_addr;
   logic [VALUE_BITS-1:0]   ring_rd_data;
   logic [VALUE_BITS-1:0]   sample_value;
   logic                    emit;
   logic [LEN_BITS-1:0]     emit_len;
   logic                    emit_ovf;
   logic                    out_busy;
   logic                    rsp_valid_ff;
   logic [LEN_BITS-1:0]     rsp_len_ff;
   logic                    rsp_ovf_ff;

   assign sample_value = req_tdata[VALUE_BITS-1:0];
   assign out_busy     = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = RSP_BITS'({rsp_ovf_ff, rsp_len_ff});

   swsal_ctrl #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS),
      .PTR_BITS   (PTR_BITS),
      .LEN_BITS   (LEN_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .in_valid     (req_tvalid),
      .in_ready     (req_tready),
      .in_value     (sample_value),
      .in_last      (req_tlast),
      .out_busy     (out_busy),
      .emit         (emit),
      .emit_len     (emit_len),
      .emit_ovf     (emit_ovf),
      .ring_ctl     (ring_ctl),
      .ring_wr_addr (ring_wr_addr),
      .ring_rd_addr (ring_rd_addr),
      .ring_rd_data (ring_rd_data)
   );

   swsal_ring #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS),
      .PTR_BITS   (PTR_BITS)
   ) u_ring (
      .clock      (clock),
      .ctl        (ring_ctl),
      .wr_addr    (ring_wr_addr),
      .wr_data    (sample_value),
      .rd_addr    (ring_rd_addr),
      .rd_data_ff (ring_rd_data)
   );

   // result register: load on emit, drop after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_len_ff <= emit_len;
         rsp_ovf_ff <= emit_ovf;
      end
   end

endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Testbench for shortest_window_sum_at_least: directed table, then random sequences vs. a predictor.
`timescale 1ns / 1ps
module tb;

   localparam int DEPTH       = 1024;
   localparam int VALUE_BITS  = 16;
   localparam int TARGET_BITS = swsal_pkg::TARGET_BITS;
   localparam int LEN_BITS    = $clog2(DEPTH + 1);
   localparam int REQ_BITS    = ((VALUE_BITS + 7) / 8) * 8;
   localparam int RSP_BITS    = ((LEN_BITS + 8) / 8) * 8;
   localparam int ITEM_GOAL   = 1750;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 20000;

   typedef struct packed {
      logic [LEN_BITS-1:0] min_length;
      logic                overflowed;
   } span_result_type;

   typedef enum logic [1:0] {
      ROW_TARGET,
      ROW_SAMPLE,
      ROW_SAMPLE_TYPED
   } row_kind_type;

   // value holds the target for ROW_TARGET rows, the sample otherwise
   typedef struct packed {
      row_kind_type        kind;
      logic [31:0]         value;
      logic                last;
      logic [LEN_BITS-1:0] len;
      logic                ovf;
   } row_type;

   localparam int DIR_ROWS_N = 23;
   localparam row_type DIR_ROWS [DIR_ROWS_N] = '{
      '{ROW_SAMPLE_TYPED, 32'd0,        1'b1, 11'd1 - 11'd1, 1'b0},  // lone zero, target 1
      '{ROW_SAMPLE_TYPED, 32'd65535,    1'b1, 11'd1, 1'b0},
      '{ROW_SAMPLE,       32'd5,        1'b0, 11'd0, 1'b0},
      '{ROW_SAMPLE_TYPED, 32'd0,        1'b1, 11'd1, 1'b0},
      '{ROW_TARGET,       32'd0,        1'b0, 11'd0, 1'b0},          // zero target
      '{ROW_SAMPLE_TYPED, 32'd0,        1'b1, 11'd1, 1'b0},
      '{ROW_SAMPLE,       32'd0,        1'b0, 11'd0, 1'b0},
      '{ROW_SAMPLE_TYPED, 32'd0,        1'b1, 11'd1, 1'b0},
      '{ROW_TARGET,       32'h3FFFFFF,  1'b0, 11'd0, 1'b0},          // unreachable target
      '{ROW_SAMPLE,       32'd65535,    1'b0, 11'd0, 1'b0},
      '{ROW_SAMPLE,       32'd65535,    1'b0, 11'd0, 1'b0},
      '{ROW_SAMPLE_TYPED, 32'd65535,    1'b1, 11'd0, 1'b0},
      '{ROW_TARGET,       32'd100,      1'b0, 11'd0, 1'b0},
      '{ROW_SAMPLE,       32'd40,       1'b0, 11'd0, 1'b0},
      '{ROW_SAMPLE,       32'd30,       1'b0, 11'd0, 1'b0},
      '{ROW_SAMPLE,       32'd50,       1'b0, 11'd0, 1'b0},
      '{ROW_SAMPLE,       32'd60,       1'b1, 11'd0, 1'b0},
      '{ROW_SAMPLE_TYPED, 32'd100,      1'b1, 11'd1, 1'b0},
      '{ROW_TARGET,       32'd65536,    1'b0, 11'd0, 1'b0},
      '{ROW_SAMPLE,       32'h5555,     1'b0, 11'd0, 1'b0},
      '{ROW_SAMPLE,       32'hAAAA,     1'b0, 11'd0, 1'b0},
      '{ROW_SAMPLE,       32'd1,        1'b1, 11'd0, 1'b0},
      '{ROW_TARGET,       32'd1,        1'b0, 11'd0, 1'b0}
   };

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   csr_we     = 1'b0;
   logic [TARGET_BITS-1:0] csr_wdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_BITS-1:0]    req_tdata  = '0;  // [15:0] sample_value
   logic                   req_tlast  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]    rsp_tdata;        // [10:0] min_length, [11] overflowed

   shortest_window_sum_at_least #(
      .DEPTH      (DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // window predictor state
   logic [VALUE_BITS-1:0]  window_copy [DEPTH];
   logic [TARGET_BITS-1:0] target_q   = TARGET_BITS'(1);
   longint unsigned        window_sum = 0;
   int unsigned            head_idx   = 0;
   int unsigned            tail_idx   = 0;
   int unsigned            window_len = 0;
   int unsigned            best_len   = 0;
   int unsigned            seen_cnt   = 0;
   bit                     over_seen  = 1'b0;

   span_result_type pending_spans [$];
   int unsigned     span_mismatches = 0;
   int unsigned     samples_sent    = 0;
   bit              steady_flow     = 1'b0;
   bit              hold_request    = 1'b0;
   int unsigned     hold_left       = 0;
   int unsigned     ready_wait      = 0;
   int unsigned     quiet_cycles    = 0;

   // Shrink the window from the front while the target is met; emit on the last value.
   function automatic bit window_feed(input logic [VALUE_BITS-1:0] value, input bit last,
                                      output span_result_type res);
      res = '0;
      if (seen_cnt >= DEPTH) begin
         over_seen = 1'b1;
      end else begin
         seen_cnt++;
         window_copy[tail_idx] = value;
         tail_idx = (tail_idx + 1) % DEPTH;
         window_sum += value;
         window_len++;
         while (window_len > 0 && window_sum >= target_q) begin
            if (best_len == 0 || window_len < best_len) begin
               best_len = window_len;
            end
            window_sum -= window_copy[head_idx];
            head_idx = (head_idx + 1) % DEPTH;
            window_len--;
         end
      end
      if (!last) begin
         return 1'b0;
      end
      res.min_length = best_len[LEN_BITS-1:0];
      res.overflowed = over_seen;
      window_sum = 0;
      head_idx   = 0;
      tail_idx   = 0;
      window_len = 0;
      best_len   = 0;
      seen_cnt   = 0;
      over_seen  = 1'b0;
      return 1'b1;
   endfunction

   function automatic void report_mismatch(input string what, input span_result_type want,
                                           input span_result_type got);
      span_mismatches++;
      if (span_mismatches <= 10) begin
         $display("%0t mismatch (%s): expected length %0d overflow %0d, got length %0d overflow %0d",
                  $realtime, what, want.min_length, want.overflowed,
                  got.min_length, got.overflowed);
      end
   endfunction

   task automatic send_sample(input logic [VALUE_BITS-1:0] value, input bit last,
                              input bit typed, input span_result_type typed_res);
      int unsigned     gap;
      span_result_type predicted;
      gap = steady_flow ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_BITS'(value);
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      if (window_feed(value, last, predicted)) begin
         pending_spans.push_back(typed ? typed_res : predicted);
      end
      samples_sent++;
   endtask

   // Drop valid, wait out every pending result, then let the block go idle.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_spans.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_target(input logic [TARGET_BITS-1:0] value);
      settle_block();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      target_q = value;
   endtask

   // result side: random stall per transfer, plus a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_wait = 0;
      end else begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (rsp_tvalid && rsp_tready) begin
            ready_wait = steady_flow ? 0 : $urandom_range(0, 9);
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (ready_wait != 0) begin
            ready_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : result_check
      span_result_type got;
      span_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.min_length = rsp_tdata[LEN_BITS-1:0];
         got.overflowed = rsp_tdata[LEN_BITS];
         if (pending_spans.size() == 0) begin
            report_mismatch("no result pending", '0, got);
         end else begin
            want = pending_spans.pop_front();
            if (got.min_length !== want.min_length) begin
               report_mismatch("min_length", want, got);
            end else if (got.overflowed !== want.overflowed) begin
               report_mismatch("overflowed", want, got);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || csr_we || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles++;
      end
   end

   initial begin
      int unsigned            phase;
      int unsigned            seq_len;
      int unsigned            sent_here;
      logic [TARGET_BITS-1:0] tgt;
      logic [VALUE_BITS-1:0]  val;
      bit                     small_vals;
      phase = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIR_ROWS[i]) begin
         if (DIR_ROWS[i].kind == ROW_TARGET) begin
            write_target(DIR_ROWS[i].value[TARGET_BITS-1:0]);
         end else begin
            send_sample(DIR_ROWS[i].value[VALUE_BITS-1:0], DIR_ROWS[i].last,
                        DIR_ROWS[i].kind == ROW_SAMPLE_TYPED,
                        span_result_type'({DIR_ROWS[i].len, DIR_ROWS[i].ovf}));
         end
      end

      while (samples_sent < ITEM_GOAL) begin
         if (phase == 2) begin
            // run past the ring depth; the ignored tail carries the last flag
            steady_flow = 1'b0;
            write_target(TARGET_BITS'($urandom_range(20, 400)));
            seq_len = DEPTH + $urandom_range(1, 6);
            for (int k = 1; k <= seq_len; k++) begin
               send_sample(VALUE_BITS'($urandom_range(0, 7)), k == seq_len, 1'b0, '0);
            end
         end else begin
            case ($urandom_range(0, 5))
               0: begin tgt = TARGET_BITS'(1);           small_vals = 1'b1; end
               1: begin tgt = '1;                        small_vals = 1'b0; end
               2: begin tgt = '0;                        small_vals = 1'b1; end
               3: begin
                  tgt = TARGET_BITS'($urandom_range(1, 300));
                  small_vals = 1'b1;
               end
               default: begin
                  tgt = TARGET_BITS'($urandom_range(1, 500000));
                  small_vals = 1'b0;
               end
            endcase
            if (phase == 1) begin
               tgt = TARGET_BITS'($urandom_range(1, 200000));
               small_vals = 1'b0;
            end
            write_target(tgt);
            steady_flow = (phase == 1) || (phase % 5 == 3);
            if (phase == 1) begin
               hold_request = 1'b1;
            end
            sent_here = 0;
            while (sent_here < 60 && samples_sent < ITEM_GOAL) begin
               if (phase == 1) begin
                  seq_len = $urandom_range(1, 3);
               end else if ($urandom_range(0, 7) == 0) begin
                  seq_len = $urandom_range(13, 40);
               end else begin
                  seq_len = $urandom_range(1, 12);
               end
               for (int k = 1; k <= seq_len; k++) begin
                  if (small_vals && $urandom_range(0, 9) != 0) begin
                     val = VALUE_BITS'($urandom_range(0, 63));
                  end else begin
                     val = VALUE_BITS'($urandom());
                  end
                  send_sample(val, k == seq_len, 1'b0, '0);
               end
               sent_here += seq_len;
            end
         end
         phase++;
      end

      settle_block();
      repeat (16) @(posedge clock);
      if (span_mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
